FILE: rtl/tns_pkg.sv
// ----------------------------------------------------------------------------
// tns_pkg
// Shared types and constants for the tone note sequencer.
// ----------------------------------------------------------------------------
package tns_pkg;

  localparam int DIV_DW = 48;   // dividend / quotient width of the serial divider
  localparam int DIV_SW = 24;   // divisor / remainder width
  localparam int DIV_CW = 6;    // divider step counter width

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_WR_TRK = 3'd1;
  localparam logic [2:0] OP_WR_PER = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_MUTE   = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  address;
    logic [6:0]  note_index;
    logic [7:0]  length_units;
    logic [23:0] period_value;
    logic [10:0] track_pairs;
    logic [11:0] tempo_ms;
  } in_item_t;

  typedef struct packed {
    logic        pin_level;
    logic [23:0] reload_value;
    logic [6:0]  note_now;
    logic [9:0]  position_now;
    logic        step_taken;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
    logic [DIV_SW-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/tns_div.sv
// ----------------------------------------------------------------------------
// tns_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tns_div
  import tns_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_SW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_SW-1:0] dsr_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_SW:0]   shifted;
  logic [DIV_SW:0]   diff;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_DW-1]};
    diff    = shifted - {1'b0, dsr_r};
    if (!diff[DIV_SW]) begin
      rem_nxt = diff[DIV_SW-1:0];
      quo_nxt = {quo_r[DIV_DW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIV_SW-1:0];
      quo_nxt = {quo_r[DIV_DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: rtl/tone_note_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tone_note_sequencer_unit
// Buzzer note sequencer: track and period tables, beat counting, tone output.
// ----------------------------------------------------------------------------
// One item is handled at a time. A track write or a start first subtracts
// TRACK_DEPTH from the address until it is in range (never for the default
// depth). A tick that ends the beat, and a start, read the pair from the
// track memory and, unless the pair is silent, its period from the period
// table. The 48-step serial divider computes clock over half-period, and
// the beat product is divided by 1000 with a reciprocal multiply. A
// finished result waits until the output register is free, so an earlier
// result held by out_stall also holds the item.
module tone_note_sequencer_unit
  import tns_pkg::*;
#(
  parameter int TRACK_DEPTH = 1024,
  parameter int NOTE_COUNT  = 64,
  parameter int CLOCK_HZ    = 40000000
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW  = $clog2(TRACK_DEPTH);
  localparam int LW  = $clog2(TRACK_DEPTH + 1);
  localparam int NW  = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int HZW = $clog2(CLOCK_HZ + 1);
  localparam int PRW = 20 + HZW;
  localparam int SIL_RAW = CLOCK_HZ / 2000;
  localparam logic [23:0] SIL_PER = 24'((SIL_RAW == 0) ? 1 : SIL_RAW);
  localparam logic [DIV_DW-1:0] CLK_DVD   = DIV_DW'(CLOCK_HZ);
  // x / 1000 = (x >> 3) / 125 = ((x >> 3) * RCP_M) >> 50, exact below 2^50
  localparam logic [43:0] RCP_M = 44'd9007199254741;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WMOD = 4'd1;
  localparam logic [3:0] S_BMOD = 4'd2;
  localparam logic [3:0] S_ADDR = 4'd3;
  localparam logic [3:0] S_TRK  = 4'd4;
  localparam logic [3:0] S_PER  = 4'd5;
  localparam logic [3:0] S_DIV1 = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DST  = 4'd8;
  localparam logic [3:0] S_DIV2 = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  logic [14:0] trk_mem [TRACK_DEPTH];
  logic [23:0] per_mem [NOTE_COUNT];

  logic [3:0]  state_r;
  in_item_t    item_r;
  logic [9:0]  amod_r;
  logic [AW-1:0] base_r;
  logic [LW-1:0] len_r;
  logic [11:0] tempo_r;
  logic [AW-1:0] pos_r;
  logic [6:0]  note_r;
  logic [23:0] hp_r;
  logic [31:0] ticks_r;
  logic        pin_r;
  logic        muted_r;
  logic        step_r;
  logic [19:0] lt_r;
  logic [HZW-1:0] hz_r;
  logic [PRW-1:0] prod_r;
  logic [47:0] rx_r;
  logic [61:0] acc_r;
  logic [1:0]  rcnt_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic          trk_we;
  logic [AW-1:0] trk_waddr;
  logic [AW-1:0] trk_raddr;
  logic [14:0]   trk_rd;
  logic          per_we;
  logic [NW-1:0] per_waddr;
  logic [NW-1:0] per_raddr;
  logic [23:0]   per_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          accept;
  logic          amod_big;
  logic [AW:0]   addr_sum;
  logic [7:0]    wr_m1;
  logic [7:0]    rd_m1;
  logic [6:0]    rd_note;
  logic          rd_note_ok;
  logic [23:0]   per_fix;
  logic [AW:0]   pos_inc;
  logic [LW-1:0] pairs_fix;
  logic          out_free;
  logic [59:0]   pp;
  logic [61:0]   acc_nxt;
  logic [43:0]   q_nxt;

  tns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    addr_sum = {1'b0, base_r} + {1'b0, pos_r};
    if (addr_sum >= (AW+1)'(TRACK_DEPTH)) addr_sum = addr_sum - (AW+1)'(TRACK_DEPTH);
    amod_big   = (32'(amod_r) >= 32'(TRACK_DEPTH));
    wr_m1      = {1'b0, in_item.note_index} - 8'd1;
    rd_note    = trk_rd[14:8];
    rd_m1      = {1'b0, rd_note} - 8'd1;
    rd_note_ok = (rd_note != 7'd0) && ({1'b0, rd_note} <= 8'(NOTE_COUNT));
    per_fix    = (per_rd == 24'd0) ? 24'd1 : per_rd;
    pos_inc    = {1'b0, pos_r} + 1'b1;
    if (item_r.track_pairs == 11'd0) pairs_fix = LW'(1);
    else if (32'(item_r.track_pairs) > 32'(TRACK_DEPTH)) pairs_fix = LW'(TRACK_DEPTH);
    else pairs_fix = LW'(item_r.track_pairs);
  end

  // reciprocal multiply, 16 bits of the dividend per cycle, low bits first
  always_comb begin
    pp      = 60'(rx_r[15:0]) * 60'(RCP_M);
    acc_nxt = (acc_r >> 16) + 62'(pp);
    q_nxt   = acc_nxt[61:18];
  end

  // memory port controls
  always_comb begin
    trk_we    = (state_r == S_WMOD) && !amod_big;
    trk_waddr = AW'(amod_r);
    trk_raddr = addr_sum[AW-1:0];
    per_we    = accept && (in_item.operation == OP_WR_PER) && (in_item.note_index != 7'd0) &&
                ({1'b0, in_item.note_index} <= 8'(NOTE_COUNT));
    per_waddr = wr_m1[NW-1:0];
    per_raddr = rd_m1[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (trk_we) trk_mem[trk_waddr] <= {item_r.note_index, item_r.length_units};
    trk_rd <= trk_mem[trk_raddr];
  end

  always_ff @(posedge clk) begin
    if (per_we) per_mem[per_waddr] <= in_item.period_value;
    per_rd <= per_mem[per_raddr];
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_TRK && !rd_note_ok) begin
      div_req.start    = 1'b1;
      div_req.dividend = CLK_DVD;
      div_req.divisor  = SIL_PER;
    end else if (state_r == S_PER) begin
      div_req.start    = 1'b1;
      div_req.dividend = CLK_DVD;
      div_req.divisor  = per_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      len_r       <= LW'(1);
      tempo_r     <= 12'd1;
      pos_r       <= '0;
      note_r      <= '0;
      hp_r        <= SIL_PER;
      ticks_r     <= 32'd1;
      pin_r       <= 1'b0;
      muted_r     <= 1'b0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r <= in_item;
            case (in_item.operation)
              OP_TICK: begin
                pin_r <= !(pin_r || note_r == 7'd0 || muted_r);
                if (ticks_r <= 32'd1) begin
                  pos_r   <= (pos_inc >= (AW+1)'(len_r)) ? '0 : pos_inc[AW-1:0];
                  state_r <= S_ADDR;
                end else begin
                  ticks_r <= ticks_r - 32'd1;
                  step_r  <= 1'b0;
                  state_r <= S_EMIT;
                end
              end
              OP_WR_TRK: begin
                amod_r  <= in_item.address;
                state_r <= S_WMOD;
              end
              OP_START: begin
                amod_r  <= in_item.address;
                state_r <= S_BMOD;
              end
              OP_MUTE:   muted_r <= !muted_r;
              default:   ;
            endcase
          end
        end
        S_WMOD: begin
          if (amod_big) amod_r <= amod_r - 10'(TRACK_DEPTH);
          else state_r <= S_IDLE;
        end
        S_BMOD: begin
          if (amod_big) begin
            amod_r <= amod_r - 10'(TRACK_DEPTH);
          end else begin
            base_r  <= AW'(amod_r);
            len_r   <= pairs_fix;
            tempo_r <= item_r.tempo_ms;
            pos_r   <= '0;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: state_r <= S_TRK;
        S_TRK: begin
          lt_r <= 20'(trk_rd[7:0]) * 20'(tempo_r);
          if (rd_note_ok) begin
            note_r  <= rd_note;
            state_r <= S_PER;
          end else begin
            note_r  <= 7'd0;
            hp_r    <= SIL_PER;
            state_r <= S_DIV1;
          end
        end
        S_PER: begin
          hp_r    <= per_fix;
          state_r <= S_DIV1;
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            hz_r    <= div_rsp.quotient[HZW-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PRW'(lt_r) * PRW'(hz_r);
          state_r <= S_DST;
        end
        S_DST: begin
          rx_r    <= 48'(prod_r >> 3);
          acc_r   <= '0;
          rcnt_r  <= '0;
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          if (rcnt_r == 2'd2) begin
            if (q_nxt[43:32] != '0) ticks_r <= 32'hFFFF_FFFF;
            else if (q_nxt[31:0] == 32'd0) ticks_r <= 32'd1;
            else ticks_r <= q_nxt[31:0];
            step_r  <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            acc_r  <= acc_nxt;
            rx_r   <= rx_r >> 16;
            rcnt_r <= rcnt_r + 2'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_r.pin_level    <= pin_r;
      out_r.reload_value <= hp_r - 24'd1;
      out_r.note_now     <= note_r;
      out_r.position_now <= 10'(pos_r);
      out_r.step_taken   <= step_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
